@@ hdl/gcd_lcm_unit_core_defines.svh @@
// Assertion macros of the gcd/lcm unit checker.
`ifndef GCD_LCM_UNIT_CORE_DEFINES_SVH
`define GCD_LCM_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define GCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset.
`define GCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/gcl_pkg.sv @@
// Shared constants and types of the gcd/lcm unit.
package gcl_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int OP_PORT_W     = 32;
	localparam int LCM_W         = 64;
	localparam int CNT_W         = $clog2(OPERAND_WIDTH + 1);

	typedef logic [OPERAND_WIDTH-1:0] opnd_t;

	typedef struct packed {
		logic  go;
		opnd_t dividend;
		opnd_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		opnd_t quotient;
		opnd_t remainder;
	} div_rsp_t;

endpackage

@@ hdl/gcd_lcm_unit_core.sv @@
// Top level of the gcd/lcm unit: request sequencer around the shared divider.
//
// A request is taken when start is high and busy is low; only the low
// OPERAND_WIDTH bits of each operand are used. The gcd comes from Euclid's
// remainder steps and the lcm from (a / gcd) * b, all divisions running on
// one shift-subtract divider that retires one bit per cycle. A request
// needing k remainder steps runs k + 1 divisions; k is at most 46 for
// 32-bit operands. A zero-operand request shows its result in the next cycle.
// The result shows for exactly one cycle with done high and cannot be held
// off; busy drops in that same cycle, so the next request may follow at once.
module gcd_lcm_unit_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gcl_pkg::OP_PORT_W-1:0] operand_a,
	input  logic [gcl_pkg::OP_PORT_W-1:0] operand_b,
	output logic                          done,
	output logic [gcl_pkg::OP_PORT_W-1:0] gcd_value,
	output logic [gcl_pkg::LCM_W-1:0]     lcm_value,
	output logic                          zero_operand
);
	import gcl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EUCLID,
		S_QUOT
	} state_t;

	state_t                 state_q;
	logic                   go_q;
	opnd_t                  dvd_q;
	opnd_t                  dvs_q;
	opnd_t                  a_q;
	opnd_t                  b_q;
	opnd_t                  gcd_q;
	logic [LCM_W-1:0]       lcm_q;
	logic                   zero_q;
	logic                   done_q;
	opnd_t                  a_m;
	opnd_t                  b_m;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	assign a_m = operand_a[OPERAND_WIDTH-1:0];
	assign b_m = operand_b[OPERAND_WIDTH-1:0];

	assign div_req.go       = go_q;
	assign div_req.dividend = dvd_q;
	assign div_req.divisor  = dvs_q;

	gcl_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
			dvd_q   <= '0;
			dvs_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			gcd_q   <= '0;
			lcm_q   <= '0;
			zero_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (a_m == '0 || b_m == '0) begin
							gcd_q  <= (a_m == '0) ? b_m : a_m;
							lcm_q  <= '0;
							zero_q <= 1'b1;
							done_q <= 1'b1;
						end else begin
							a_q     <= a_m;
							b_q     <= b_m;
							dvd_q   <= a_m;
							dvs_q   <= b_m;
							go_q    <= 1'b1;
							state_q <= S_EUCLID;
						end
					end
				end
				S_EUCLID: begin
					if (div_rsp.done) begin
						if (div_rsp.remainder == '0) begin
							gcd_q   <= dvs_q;
							dvd_q   <= a_q;
							go_q    <= 1'b1;
							state_q <= S_QUOT;
						end else begin
							dvd_q <= dvs_q;
							dvs_q <= div_rsp.remainder;
							go_q  <= 1'b1;
						end
					end
				end
				S_QUOT: begin
					if (div_rsp.done) begin
						lcm_q   <= LCM_W'(div_rsp.quotient) * LCM_W'(b_q);
						zero_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign gcd_value    = OP_PORT_W'(gcd_q);
	assign lcm_value    = lcm_q;
	assign zero_operand = zero_q;

endmodule

@@ hdl/gcl_divider.sv @@
// Shared restoring shift-subtract divider, one quotient bit per cycle.
module gcl_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  gcl_pkg::div_req_t req,
	output gcl_pkg::div_rsp_t rsp
);
	import gcl_pkg::*;

	logic                     run_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	opnd_t                    rem_q;
	opnd_t                    quo_q;
	opnd_t                    dvs_q;
	logic [OPERAND_WIDTH:0]   rem_sh;
	logic [OPERAND_WIDTH:0]   diff;
	logic                     fits;
	opnd_t                    rem_next;
	opnd_t                    quo_next;

	always_comb begin
		rem_sh   = {rem_q, quo_q[OPERAND_WIDTH-1]};
		diff     = rem_sh - {1'b0, dvs_q};
		fits     = (rem_sh >= {1'b0, dvs_q});
		rem_next = fits ? diff[OPERAND_WIDTH-1:0] : rem_sh[OPERAND_WIDTH-1:0];
		quo_next = {quo_q[OPERAND_WIDTH-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(OPERAND_WIDTH);
				rem_q <= '0;
				quo_q <= req.dividend;
				dvs_q <= req.divisor;
			end else if (run_q) begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

@@ hdl/gcl_checker.sv @@
// Port-level checker of the gcd/lcm unit and its bind to the top level.
`include "gcd_lcm_unit_core_defines.svh"

module gcl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [gcl_pkg::OP_PORT_W-1:0] operand_a,
	input logic [gcl_pkg::OP_PORT_W-1:0] operand_b,
	input logic                          done,
	input logic [gcl_pkg::OP_PORT_W-1:0] gcd_value,
	input logic [gcl_pkg::LCM_W-1:0]     lcm_value,
	input logic                          zero_operand
);
	import gcl_pkg::*;

	logic take;
	logic zero_in;

	assign take    = start && !busy;
	assign zero_in = (operand_a[OPERAND_WIDTH-1:0] == '0) ||
		(operand_b[OPERAND_WIDTH-1:0] == '0);

	`GCL_ASSERT_NEXT(a_zero_fast, take && zero_in, done && zero_operand, "zero request not done next cycle")
	`GCL_ASSERT_NEXT(a_busy_work, take && !zero_in, busy && !done, "nonzero request did not start work")
	`GCL_ASSERT_NOW(a_zero_lcm, done && zero_operand, lcm_value == '0, "lcm not zero for zero operand")
	`GCL_ASSERT_NOW(a_nz_result, done && !zero_operand, gcd_value != '0 && lcm_value != '0, "zero result for nonzero operands")
	`GCL_ASSERT_NOW(a_done_idle, done, !busy, "busy while result shown")

endmodule

bind gcd_lcm_unit_core gcl_checker u_gcl_checker (.*);
